// ----- hw/rtl/lae_pkg.sv -----
// Shared types, constants and the echo prefix table for the line assembler.
package lae_pkg;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  localparam int unsigned PFX_LEN = 10;
  localparam int unsigned PFX_W   = $clog2(PFX_LEN);

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } lae_in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } lae_out_t;

  typedef enum logic {
    REQ_BYTE    = 1'b0,
    REQ_PROCESS = 1'b1
  } lae_req_e;

  typedef enum logic [1:0] {
    SEL_PREFIX,
    SEL_LINE,
    SEL_CR,
    SEL_LF
  } lae_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREFIX,
    ST_READ,
    ST_EMIT,
    ST_CR,
    ST_LF
  } lae_state_e;

  typedef struct packed {
    logic     rx_take;
    logic     clr_line;
    logic     idx_clr;
    logic     idx_inc;
    logic     pfx_inc;
    logic     rd_en;
    logic     out_load;
    lae_sel_e out_sel;
  } lae_cmd_t;

  typedef struct packed {
    logic line_ready;
    logic pfx_last;
    logic idx_last;
    logic rd_zero;
    logic out_free;
  } lae_status_t;

  function automatic logic [7:0] prefix_byte(input logic [PFX_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h52;
      4'd1:    b = 8'h65;
      4'd2:    b = 8'h63;
      4'd3:    b = 8'h65;
      4'd4:    b = 8'h69;
      4'd5:    b = 8'h76;
      4'd6:    b = 8'h65;
      4'd7:    b = 8'h64;
      4'd8:    b = 8'h3A;
      4'd9:    b = 8'h20;
      default: b = 8'h20;
    endcase
    return b;
  endfunction

endpackage

// ----- hw/rtl/lae_stream_if.sv -----
// Valid/ready word channel carrying one payload struct.
interface lae_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/lae_datapath.sv -----
// Line store, length and ready flags, echo counters and output register.
module lae_datapath #(
  parameter int unsigned LINE_BUFFER_BYTES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lae_pkg::lae_in_t  in_data_i,
  input  lae_pkg::lae_cmd_t cmd_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output lae_pkg::lae_out_t out_data_o,
  output lae_pkg::lae_status_t status_o
);

  localparam int unsigned LEN_W = $clog2(LINE_BUFFER_BYTES);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(LINE_BUFFER_BYTES - 1);

  logic [7:0]             mem_q [LINE_BUFFER_BYTES];
  logic [LEN_W-1:0]       len_q, len_d;
  logic                   ready_q, ready_d;
  logic                   wr_en;
  logic [LEN_W-1:0]       idx_q, idx_d;
  logic [lae_pkg::PFX_W-1:0] pfx_q, pfx_d;
  logic [7:0]             rd_q;
  logic                   out_valid_q, out_valid_d;
  lae_pkg::lae_out_t      out_data_q, out_data_d;
  logic                   is_eol;

  assign is_eol = (in_data_i.rx_byte == lae_pkg::CHAR_CR) ||
                  (in_data_i.rx_byte == lae_pkg::CHAR_LF);

  always_comb begin
    len_d   = len_q;
    ready_d = ready_q;
    wr_en   = 1'b0;
    if (cmd_i.clr_line) begin
      len_d   = '0;
      ready_d = 1'b0;
    end else if (cmd_i.rx_take) begin
      if (is_eol) begin
        if (len_q != '0) begin
          ready_d = 1'b1;
        end
      end else if (!ready_q) begin
        if (len_q < MAX_LEN) begin
          wr_en = 1'b1;
          len_d = len_q + LEN_W'(1);
        end else begin
          len_d   = '0;
          ready_d = 1'b0;
        end
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    pfx_d = pfx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
      pfx_d = '0;
    end else begin
      if (cmd_i.idx_inc) begin
        idx_d = idx_q + LEN_W'(1);
      end
      if (cmd_i.pfx_inc) begin
        pfx_d = pfx_q + lae_pkg::PFX_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      unique case (cmd_i.out_sel)
        lae_pkg::SEL_PREFIX: out_data_d = '{tx_byte: lae_pkg::prefix_byte(pfx_q), last: 1'b0};
        lae_pkg::SEL_LINE:   out_data_d = '{tx_byte: rd_q, last: 1'b0};
        lae_pkg::SEL_CR:     out_data_d = '{tx_byte: lae_pkg::CHAR_CR, last: 1'b0};
        lae_pkg::SEL_LF:     out_data_d = '{tx_byte: lae_pkg::CHAR_LF, last: 1'b1};
        default:             out_data_d = '{tx_byte: lae_pkg::CHAR_LF, last: 1'b1};
      endcase
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ready_q     <= 1'b0;
      idx_q       <= '0;
      pfx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      ready_q     <= ready_d;
      idx_q       <= idx_d;
      pfx_q       <= pfx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[len_q] <= in_data_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[idx_q];
    end
  end

  assign status_o.line_ready = ready_q;
  assign status_o.pfx_last   = (pfx_q == lae_pkg::PFX_W'(lae_pkg::PFX_LEN - 1));
  assign status_o.idx_last   = (idx_q == len_q - LEN_W'(1));
  assign status_o.rd_zero    = (rd_q == lae_pkg::CHAR_NUL);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- hw/rtl/lae_ctrl.sv -----
// Sequencer for input intake and the echo run.
module lae_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_req_i,
  output logic                 in_ready_o,
  input  lae_pkg::lae_status_t status_i,
  output lae_pkg::lae_cmd_t    cmd_o
);

  lae_pkg::lae_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lae_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{out_sel: lae_pkg::SEL_PREFIX, default: 1'b0};
    unique case (state_q)
      lae_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_req_i == lae_pkg::REQ_BYTE) begin
            cmd_o.rx_take = 1'b1;
          end else if (status_i.line_ready) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = lae_pkg::ST_PREFIX;
          end
        end
      end
      lae_pkg::ST_PREFIX: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = lae_pkg::SEL_PREFIX;
          cmd_o.pfx_inc  = 1'b1;
          if (status_i.pfx_last) begin
            state_d = lae_pkg::ST_READ;
          end
        end
      end
      lae_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = lae_pkg::ST_EMIT;
      end
      lae_pkg::ST_EMIT: begin
        if (status_i.rd_zero) begin
          state_d = lae_pkg::ST_CR;
        end else if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = lae_pkg::SEL_LINE;
          if (status_i.idx_last) begin
            state_d = lae_pkg::ST_CR;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = lae_pkg::ST_READ;
          end
        end
      end
      lae_pkg::ST_CR: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = lae_pkg::SEL_CR;
          state_d        = lae_pkg::ST_LF;
        end
      end
      lae_pkg::ST_LF: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = lae_pkg::SEL_LF;
          cmd_o.clr_line = 1'b1;
          state_d        = lae_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lae_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/line_assembler_with_echo.sv -----
// Line assembler top level: collects received bytes into a line and echoes it on request.
// Each received byte is handled as it is taken: non-CR/LF bytes append to the line store while no line is
// ready, CR or LF marks a non-empty line ready, and a byte that would overflow
// LINE_BUFFER_BYTES-1 stored bytes clears the line. A process request on a ready line is
// accepted and then emits "Received: ", the stored bytes up to the first zero
// byte, and CR LF with last set on the LF; each line byte passes through the registered
// read port of the line store before it reaches the output register. No input word is taken
// during a run; a request on a line that is not ready is consumed without output. The line
// store needs no clearing after reset.
module line_assembler_with_echo #(
  parameter int unsigned LINE_BUFFER_BYTES = 32
) (
  input logic          clk_i,
  input logic          rst_ni,
  lae_stream_if.sink   in_i,
  lae_stream_if.source out_o
);

  lae_pkg::lae_cmd_t    cmd;
  lae_pkg::lae_status_t status;
  lae_pkg::lae_in_t     in_data;
  lae_pkg::lae_out_t    out_data;

  assign in_data    = in_i.data;
  assign out_o.data = out_data;

  lae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_req_i   (in_data.req_type),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lae_datapath #(
    .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data),
    .cmd_i       (cmd),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_data),
    .status_o    (status)
  );

endmodule

// ----- tb/line_assembler_with_echo_test.sv -----
// Self-checking testbench for the line assembler: directed table, then random lines and noise.
`timescale 1ns / 1ps

module line_assembler_with_echo_test;
  import lae_pkg::*;

  localparam int LINE_BYTES  = 32;
  localparam int RAND_WORDS  = 320;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int DIR_ROWS    = 22;

  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_SILENT,
    CHK_ECHO
  } chk_e;

  typedef struct packed {
    lae_req_e    req;
    logic [7:0]  data;
    chk_e        chk;
    logic [2:0]  txt_n;
    logic [31:0] txt;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{REQ_PROCESS, 8'h00,    CHK_SILENT,  3'd0, 32'h0},
    '{REQ_BYTE,    CHAR_CR,  CHK_SILENT,  3'd0, 32'h0},
    '{REQ_BYTE,    CHAR_LF,  CHK_SILENT,  3'd0, 32'h0},
    '{REQ_BYTE,    "H",      CHK_SILENT,  3'd0, 32'h0},
    '{REQ_BYTE,    "i",      CHK_SILENT,  3'd0, 32'h0},
    '{REQ_BYTE,    CHAR_CR,  CHK_SILENT,  3'd0, 32'h0},
    '{REQ_BYTE,    "x",      CHK_SILENT,  3'd0, 32'h0},
    '{REQ_BYTE,    CHAR_LF,  CHK_SILENT,  3'd0, 32'h0},
    '{REQ_PROCESS, 8'h00,    CHK_ECHO,    3'd2, "Hi"},
    '{REQ_PROCESS, 8'hFF,    CHK_SILENT,  3'd0, 32'h0},
    '{REQ_BYTE,    8'hFF,    CHK_PREDICT, 3'd0, 32'h0},
    '{REQ_BYTE,    CHAR_NUL, CHK_PREDICT, 3'd0, 32'h0},
    '{REQ_BYTE,    8'h7E,    CHK_PREDICT, 3'd0, 32'h0},
    '{REQ_BYTE,    CHAR_LF,  CHK_PREDICT, 3'd0, 32'h0},
    '{REQ_PROCESS, 8'h00,    CHK_PREDICT, 3'd0, 32'h0},
    '{REQ_BYTE,    CHAR_NUL, CHK_PREDICT, 3'd0, 32'h0},
    '{REQ_BYTE,    8'h01,    CHK_PREDICT, 3'd0, 32'h0},
    '{REQ_BYTE,    CHAR_CR,  CHK_PREDICT, 3'd0, 32'h0},
    '{REQ_PROCESS, 8'h00,    CHK_ECHO,    3'd0, 32'h0},
    '{REQ_BYTE,    8'h80,    CHK_PREDICT, 3'd0, 32'h0},
    '{REQ_BYTE,    CHAR_LF,  CHK_PREDICT, 3'd0, 32'h0},
    '{REQ_PROCESS, 8'hFF,    CHK_PREDICT, 3'd0, 32'h0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lae_stream_if #(.payload_t(lae_in_t))  in_ch ();
  lae_stream_if #(.payload_t(lae_out_t)) out_ch ();

  line_assembler_with_echo #(
    .LINE_BUFFER_BYTES(LINE_BYTES)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  string       echo_head = "Received: ";
  logic [7:0]  line_mem [LINE_BYTES];
  int          line_len = 0;
  bit          line_rdy = 1'b0;
  lae_out_t    echo_due [$];

  chk_e        row_chk   = CHK_PREDICT;
  logic [2:0]  row_txt_n = '0;
  logic [31:0] row_txt   = '0;

  int          errors      = 0;
  int          words_sent  = 0;
  int          idle_cycles = 0;
  int          src_burst   = 0;
  int          snk_burst   = 0;
  bit          hold_out    = 1'b0;

  always #1 clk_i = ~clk_i;

  function automatic lae_out_t echo_word(input logic [7:0] b, input logic is_last);
    lae_out_t r;
    r.tx_byte = b;
    r.last    = is_last;
    return r;
  endfunction

  function automatic void assemble_and_echo(input lae_in_t w, output lae_out_t res [$]);
    int i;
    res = {};
    if (w.req_type == REQ_BYTE) begin
      if (w.rx_byte == CHAR_CR || w.rx_byte == CHAR_LF) begin
        if (line_len > 0) line_rdy = 1'b1;
      end else if (!line_rdy) begin
        if (line_len < LINE_BYTES - 1) begin
          line_mem[line_len] = w.rx_byte;
          line_len++;
        end else begin
          line_len = 0;
        end
      end
      return;
    end
    if (!line_rdy) return;
    for (i = 0; i < echo_head.len(); i++) res.push_back(echo_word(echo_head[i], 1'b0));
    for (i = 0; i < line_len; i++) begin
      if (line_mem[i] == CHAR_NUL) break;
      res.push_back(echo_word(line_mem[i], 1'b0));
    end
    res.push_back(echo_word(CHAR_CR, 1'b0));
    res.push_back(echo_word(CHAR_LF, 1'b1));
    line_len = 0;
    line_rdy = 1'b0;
  endfunction

  function automatic int next_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [7:0] line_byte();
    logic [7:0] b;
    if ($urandom_range(0, 11) == 0) return CHAR_NUL;
    do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR || b == CHAR_LF);
    return b;
  endfunction

  task automatic drive_word(input lae_in_t w, input chk_e chk, input logic [2:0] txt_n,
                            input logic [31:0] txt);
    int gap;
    gap = next_gap(src_burst);
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    row_chk   = chk;
    row_txt_n = txt_n;
    row_txt   = txt;
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    words_sent++;
  endtask

  task automatic send_random_sequence();
    int len;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      repeat ($urandom_range(1, 4))
        drive_word(lae_in_t'($urandom_range(0, 511)), CHK_PREDICT, '0, '0);
      return;
    end
    pick = $urandom_range(0, 15);
    if (pick < 10)      len = $urandom_range(0, 6);
    else if (pick < 15) len = $urandom_range(7, LINE_BYTES - 2);
    else                len = $urandom_range(LINE_BYTES - 1, LINE_BYTES + 2);
    repeat (len) drive_word({REQ_BYTE, line_byte()}, CHK_PREDICT, '0, '0);
    if ($urandom_range(0, 7) != 0)
      drive_word({REQ_BYTE, ($urandom_range(0, 1) != 0) ? CHAR_CR : CHAR_LF},
                 CHK_PREDICT, '0, '0);
    if ($urandom_range(0, 3) == 0)
      drive_word(lae_in_t'($urandom_range(0, 511)), CHK_PREDICT, '0, '0);
    drive_word({REQ_PROCESS, 8'($urandom_range(0, 255))}, CHK_PREDICT, '0, '0);
  endtask

  always @(posedge clk_i) begin
    lae_out_t due [$];
    int k;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      assemble_and_echo(in_ch.data, due);
      if (row_chk != CHK_PREDICT) due = {};
      if (row_chk == CHK_ECHO) begin
        for (k = 0; k < echo_head.len(); k++) due.push_back(echo_word(echo_head[k], 1'b0));
        for (k = row_txt_n - 1; k >= 0; k--) due.push_back(echo_word(row_txt[8*k +: 8], 1'b0));
        due.push_back(echo_word(CHAR_CR, 1'b0));
        due.push_back(echo_word(CHAR_LF, 1'b1));
      end
      foreach (due[k]) echo_due.push_back(due[k]);
    end
  end

  always @(posedge clk_i) begin
    lae_out_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (echo_due.size() == 0) begin
        errors++;
        if (errors < 50) $error("echo word %02h with nothing expected", out_ch.data.tx_byte);
      end else begin
        want = echo_due.pop_front();
        if (out_ch.data.tx_byte !== want.tx_byte) begin
          errors++;
          if (errors < 50)
            $error("tx_byte: expected %02h, got %02h", want.tx_byte, out_ch.data.tx_byte);
        end
        if (out_ch.data.last !== want.last) begin
          errors++;
          if (errors < 50) $error("last: expected %0b, got %0b", want.last, out_ch.data.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_out) begin
        @(negedge clk_i);
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_out = 1'b0;
      end
      gap = next_gap(snk_burst);
      repeat (gap) begin
        @(negedge clk_i);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk_i);
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin
    bit paused;
    paused      = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIR_TAB[k])
      drive_word({DIR_TAB[k].req, DIR_TAB[k].data}, DIR_TAB[k].chk, DIR_TAB[k].txt_n,
                 DIR_TAB[k].txt);

    hold_out = 1'b1;
    while (words_sent < DIR_ROWS + RAND_WORDS) begin
      send_random_sequence();
      if (!paused && words_sent > DIR_ROWS + RAND_WORDS / 2) begin
        paused = 1'b1;
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
        while (echo_due.size() != 0) @(posedge clk_i);
      end
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (echo_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
